@@ rtl/krh_pkg.sv @@
// ----------------------------------------------------------------------------
// krh_pkg: shared types and constants for the k-mer rolling hash
// Widths, reset values, hash multiplier and register indexes.
// ----------------------------------------------------------------------------
package krh_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int RING_AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int FILL_W     = $clog2(MAX_WINDOW + 1);

   localparam int SYM_W      = 8;
   localparam int HASH_W     = 64;
   localparam int LEN_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [HASH_W-1:0] HASH_MULT         = 64'd100000007;
   localparam logic [HASH_W-1:0] BASE_POWER_RESET  = 64'd100000007;
   localparam logic [LEN_W-1:0]  WINDOW_LEN_RESET  = 7'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LEN = 2'd0,
      CSR_BASE_POWER = 2'd1
   } csr_index_type;

endpackage

@@ rtl/krh_if.sv @@
// ----------------------------------------------------------------------------
// krh_if: valid/ready channels of the k-mer rolling hash
// Character input, hash result and register write channels.
// ----------------------------------------------------------------------------
interface krh_req_if import krh_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] sym;
   logic             seq_start;

   modport source (output valid, sym, seq_start, input ready);
   modport sink   (input valid, sym, seq_start, output ready);
endinterface

interface krh_rsp_if import krh_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HASH_W-1:0] hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink   (input valid, hash_value, output ready);
endinterface

interface krh_csr_if import krh_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/kmer_rolling_hash.sv @@
// ----------------------------------------------------------------------------
// kmer_rolling_hash: Rabin-Karp rolling hash over a character stream
// Keeps the last window_len characters in a ring and emits one 64-bit
// hash per full window.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one character (sym) per transfer; seq_start marks the first
//   character of a new sequence and restarts the window. rsp carries one
//   hash_value per full window; characters that do not complete a window
//   produce no transfer. csr writes window_len (index 0) and base_power
//   (index 1, software loads 100000007^window_len mod 2^64); csr is always
//   ready. csr is to be written only while the block is idle; the block
//   itself does not enforce this. Throughput: one character per cycle
//   while rsp does not stall. A hash reaches rsp through the ring read and
//   stage A registers, which load at the transfer, then the delta register,
//   then the output register. The rate is set by the hash feedback loop,
//   one constant multiply-add per cycle in the last stage.
//   Reset clears the window, fill count, hash and the pipeline, and restores
//   window_len = 1 and base_power = 100000007. The ring RAM is not cleared:
//   entries are used only after the current sequence wrote them.
//   When rsp stalls, the result holds in the output register while up to two
//   more emitting characters enter the pipeline; characters that emit nothing
//   drain through without needing the output slot.
// ----------------------------------------------------------------------------
module kmer_rolling_hash import krh_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   krh_req_if.sink   req,
   krh_rsp_if.source rsp,
   krh_csr_if.sink   csr
);

   // Configuration registers
   logic [LEN_W-1:0]  window_len_ff, window_len_in;
   logic [HASH_W-1:0] base_power_ff, base_power_in;
   logic              csr_xfer;

   // Window control, updated at the character transfer
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [RING_AW-1:0] idx_ff, idx_in;

   // Stage A: character and its ring read in flight
   logic              a_valid_ff, a_valid_in;
   logic [SYM_W-1:0]  a_sym_ff, a_sym_in;
   logic              a_start_ff, a_start_in;
   logic              a_full_ff, a_full_in;
   logic              a_emit_ff, a_emit_in;

   // Stage B: hash delta ready for the feedback update
   logic              b_valid_ff, b_valid_in;
   logic              b_start_ff, b_start_in;
   logic              b_emit_ff, b_emit_in;
   logic [HASH_W-1:0] b_delta_ff, b_delta_in;

   // Hash state and output register
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0] rsp_hash_ff, rsp_hash_in;

   // Flow control
   logic out_free, b_take, b_load, a_load, req_xfer;

   // Acceptance-side control
   logic [FILL_W-1:0]  n_eff;
   logic [FILL_W-1:0]  fill_base;
   logic [RING_AW-1:0] slot;
   logic [RING_AW-1:0] slot_next;
   logic [FILL_W-1:0]  fill_inc;
   logic               win_full;
   logic               emit_now;

   // Datapath
   logic [SYM_W-1:0]  ring_rd_data;
   logic [HASH_W-1:0] old_prod;
   logic [HASH_W-1:0] hash_prev;
   logic [HASH_W-1:0] hash_next;

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign csr.ready = 1'b1;
   assign csr_xfer  = csr.valid && csr.ready;

   always_comb begin
      window_len_in = window_len_ff;
      base_power_in = base_power_ff;
      if (csr_xfer) begin
         unique case (csr_index_type'(csr.index))
            CSR_WINDOW_LEN: window_len_in = csr.data[LEN_W-1:0];
            CSR_BASE_POWER: base_power_in = csr.data[HASH_W-1:0];
            default: ;   // drop writes to unmapped indexes
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Flow control: each stage loads when it is empty or moving on.
   // A non-emitting item in B leaves without taking the output slot.
   // ------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign b_take    = b_valid_ff && (!b_emit_ff || out_free);
   assign b_load    = !b_valid_ff || b_take;
   assign a_load    = !a_valid_ff || b_load;
   assign req.ready = a_load;
   assign req_xfer  = req.valid && a_load;

   // ------------------------------------------------------------------
   // Window control at the character transfer
   // ------------------------------------------------------------------
   always_comb begin
      // clamp the window length to 1..MAX_WINDOW
      if (window_len_ff == '0) begin
         n_eff = FILL_W'(1);
      end else if (32'(window_len_ff) > 32'(MAX_WINDOW)) begin
         n_eff = FILL_W'(MAX_WINDOW);
      end else begin
         n_eff = FILL_W'(window_len_ff);
      end

      // a sequence start restarts the window before taking the character
      fill_base = req.seq_start ? '0 : fill_ff;
      slot      = req.seq_start ? '0 : idx_ff;
      win_full  = fill_base >= n_eff;
      fill_inc  = fill_base + FILL_W'(1);

      if (32'(slot) + 32'd1 >= 32'(n_eff)) begin
         slot_next = '0;
      end else begin
         slot_next = RING_AW'(32'(slot) + 32'd1);
      end

      fill_in  = fill_ff;
      idx_in   = idx_ff;
      emit_now = 1'b0;
      if (win_full) begin
         idx_in   = slot_next;
         emit_now = 1'b1;
      end else begin
         fill_in = fill_inc;
         if (fill_inc >= n_eff) begin
            // window just filled: the oldest character sits at slot zero
            idx_in   = '0;
            emit_now = 1'b1;
         end else begin
            idx_in = slot_next;
         end
      end
      if (!req_xfer) begin
         fill_in = fill_ff;
         idx_in  = idx_ff;
      end
   end

   // Ring of the last window characters; read the outgoing one and
   // overwrite it with the new character in the same transfer.
   krh_ram #(
      .WIDTH (SYM_W),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (req_xfer),
      .wr_addr (slot),
      .wr_data (req.sym),
      .rd_en   (req_xfer),
      .rd_addr (slot),
      .rd_data (ring_rd_data)
   );

   // ------------------------------------------------------------------
   // Stage A load
   // ------------------------------------------------------------------
   always_comb begin
      a_valid_in = a_valid_ff;
      a_sym_in   = a_sym_ff;
      a_start_in = a_start_ff;
      a_full_in  = a_full_ff;
      a_emit_in  = a_emit_ff;
      if (a_load) begin
         a_valid_in = req_xfer;
      end
      if (req_xfer) begin
         a_sym_in   = req.sym;
         a_start_in = req.seq_start;
         a_full_in  = win_full;
         a_emit_in  = emit_now;
      end
   end

   // ------------------------------------------------------------------
   // Stage A -> B: delta = sym - oldest * base_power (8 x 64 multiply)
   // ------------------------------------------------------------------
   assign old_prod = {{(HASH_W-SYM_W){1'b0}}, ring_rd_data} * base_power_ff;

   always_comb begin
      b_valid_in = b_valid_ff;
      b_start_in = b_start_ff;
      b_emit_in  = b_emit_ff;
      b_delta_in = b_delta_ff;
      if (b_load) begin
         b_valid_in = a_valid_ff;
         if (a_valid_ff) begin
            b_start_in = a_start_ff;
            b_emit_in  = a_emit_ff;
            b_delta_in = {{(HASH_W-SYM_W){1'b0}}, a_sym_ff}
                       - (a_full_ff ? old_prod : '0);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage B -> output: hash = hash * 100000007 + delta, modulo 2^64
   // ------------------------------------------------------------------
   assign hash_prev = b_start_ff ? '0 : hash_ff;
   assign hash_next = hash_prev * HASH_MULT + b_delta_ff;

   always_comb begin
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      if (b_take) begin
         hash_in = hash_next;
      end
      if (out_free) begin
         rsp_valid_in = b_take && b_emit_ff;
         if (b_take && b_emit_ff) begin
            rsp_hash_in = hash_next;
         end
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.hash_value = rsp_hash_ff;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WINDOW_LEN_RESET;
         base_power_ff <= BASE_POWER_RESET;
         fill_ff       <= '0;
         idx_ff        <= '0;
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hash_ff       <= '0;
      end else begin
         window_len_ff <= window_len_in;
         base_power_ff <= base_power_in;
         fill_ff       <= fill_in;
         idx_ff        <= idx_in;
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         hash_ff       <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sym_ff    <= a_sym_in;
      a_start_ff  <= a_start_in;
      a_full_ff   <= a_full_in;
      a_emit_ff   <= a_emit_in;
      b_start_ff  <= b_start_in;
      b_emit_ff   <= b_emit_in;
      b_delta_ff  <= b_delta_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // a sequence start always leaves exactly one character in the window
   a_start_fill: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req.seq_start) |=> (fill_ff == FILL_W'(1)))
      else $error("fill count not one after sequence start");

   // the fill count never exceeds the ring depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(MAX_WINDOW))
      else $error("fill count beyond ring depth");

   // an emitting item blocked at stage B holds its delta
   a_b_hold: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_emit_ff && !out_free) |=> (b_valid_ff && $stable(b_delta_ff)))
      else $error("stalled stage B item lost or changed");

   // a new result only comes from an emitting item leaving stage B
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(b_valid_ff && b_emit_ff))
      else $error("result without an emitting item");

   // a character transfer always fills stage A
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> a_valid_ff)
      else $error("accepted character not in stage A");

endmodule

@@ rtl/krh_ram.sv @@
// ----------------------------------------------------------------------------
// krh_ram: generic single-write, single-read RAM
// Registered read with read enable; a read and write to one address in
// the same cycle return the old contents.
// ----------------------------------------------------------------------------
module krh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
